>>> sv/kuf_pkg.sv
// Shared types and constants of the Kruskal union-find edge filter.
package kuf_pkg;

  localparam int COUNT_W  = 13;
  localparam int NODE_W   = 12;
  localparam int WEIGHT_W = 48;
  localparam int SUM_W    = 60;
  localparam int EPOCH_W  = 4;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_EDGE  = 1'b1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic                req_type;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             tree_complete;
    logic [SUM_W-1:0] total_weight;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } eng_cmd_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic joined;
  } eng_status_t;

endpackage

>>> sv/kuf_table.sv
// Parent-or-size memory: one write port, one read port with registered read data.
module kuf_table #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/kuf_engine.sv
// Union-find sequencer: table sweep, epoch tags, find with path compression, union by size.
module kuf_engine #(
  parameter int MAX_NODES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kuf_pkg::eng_cmd_t    cmd,
  output kuf_pkg::eng_status_t status
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int EW   = kuf_pkg::EPOCH_W;
  localparam int ENTW = EW + 1 + AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  typedef enum logic [2:0] {
    E_SWEEP,
    E_IDLE,
    E_WALK,
    E_COMP,
    E_MERGE_ROOT,
    E_MERGE_CHILD
  } state_t;

  state_t        state;
  logic [EW-1:0] epoch;
  logic [EW-1:0] epoch_next;
  logic [AW-1:0] sweep_addr;
  logic          second;
  logic [AW-1:0] walk_node;
  logic [AW-1:0] start_node;
  logic [AW-1:0] end_b;
  logic [AW-1:0] root_a;
  logic [AW-1:0] root_b;
  logic [AW-1:0] size_a;
  logic [AW-1:0] size_b;
  logic          done;
  logic          joined;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [ENTW-1:0] wdata;
  logic [AW-1:0]   raddr;
  logic [ENTW-1:0] rdata;

  logic          hit;
  logic          is_root;
  logic [AW-1:0] link;
  logic [AW-1:0] cur_root;
  logic [AW-1:0] big_root;
  logic [AW-1:0] small_root;
  logic [AW-1:0] merged_size;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;

  kuf_table #(
    .DEPTH(MAX_NODES),
    .WIDTH(ENTW)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign hit         = (rdata[ENTW-1 -: EW] == epoch);
  assign is_root     = !hit || rdata[AW];
  assign link        = hit ? rdata[AW-1:0] : '0;
  assign cur_root    = second ? root_b : root_a;
  assign big_root    = (size_a < size_b) ? root_b : root_a;
  assign small_root  = (size_a < size_b) ? root_a : root_b;
  assign merged_size = size_a + size_b + AW'(1);
  assign epoch_next  = epoch + EW'(1);
  assign addr_a      = AW'(cmd.node_a);
  assign addr_b      = AW'(cmd.node_b);

  always_comb begin
    we    = 1'b0;
    waddr = walk_node;
    wdata = {epoch, 1'b0, cur_root};
    raddr = walk_node;
    unique case (state)
      E_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = '0;
      end
      E_IDLE: begin
        raddr = addr_a;
      end
      E_WALK: begin
        raddr = is_root ? start_node : link;
      end
      E_COMP: begin
        if (walk_node == cur_root || is_root) begin
          raddr = end_b;
        end else begin
          we    = 1'b1;
          raddr = link;
        end
      end
      E_MERGE_ROOT: begin
        we    = 1'b1;
        waddr = big_root;
        wdata = {epoch, 1'b1, merged_size};
      end
      E_MERGE_CHILD: begin
        we    = 1'b1;
        waddr = small_root;
        wdata = {epoch, 1'b0, big_root};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= E_SWEEP;
      sweep_addr <= '0;
      epoch      <= EW'(1);
      second     <= 1'b0;
      done       <= 1'b0;
      joined     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == LAST_ADDR) begin
            epoch <= EW'(1);
            state <= E_IDLE;
          end
        end
        E_IDLE: begin
          if (cmd.start) begin
            if (cmd.clear) begin
              epoch <= epoch_next;
              if (epoch_next == '0) begin
                sweep_addr <= '0;
                state      <= E_SWEEP;
              end
            end else begin
              walk_node  <= addr_a;
              start_node <= addr_a;
              end_b      <= addr_b;
              second     <= 1'b0;
              state      <= E_WALK;
            end
          end
        end
        E_WALK: begin
          if (is_root) begin
            if (second) begin
              root_b <= walk_node;
              size_b <= link;
            end else begin
              root_a <= walk_node;
              size_a <= link;
            end
            walk_node <= start_node;
            state     <= E_COMP;
          end else begin
            walk_node <= link;
          end
        end
        E_COMP: begin
          if (walk_node == cur_root || is_root) begin
            if (!second) begin
              second     <= 1'b1;
              start_node <= end_b;
              walk_node  <= end_b;
              state      <= E_WALK;
            end else if (root_a == root_b) begin
              done   <= 1'b1;
              joined <= 1'b0;
              state  <= E_IDLE;
            end else begin
              state <= E_MERGE_ROOT;
            end
          end else begin
            walk_node <= link;
          end
        end
        E_MERGE_ROOT: begin
          state <= E_MERGE_CHILD;
        end
        E_MERGE_CHILD: begin
          done   <= 1'b1;
          joined <= 1'b1;
          state  <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign status.ready  = (state == E_IDLE);
  assign status.done   = done;
  assign status.joined = joined;

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
// Kruskal edge filter: request channel, result channel, node count register.
//
// Requests arrive on edge_valid / edge_stall / edge_item: a clear request or one
// edge with weight and two end nodes, edges in ascending weight order. Every
// request gives exactly one result on result_valid / result_stall / result_item:
// accepted, tree_complete and the saturating total of accepted weights.
// cfg_data sets the node count; it takes effect at the next clear request.
// A clear request's result is written to the pending register and then moves to
// the result register; edge_stall stays high while it is pending. For an edge,
// each find walks the parent table from its end node to the root and once more
// to compress the path, one read per cycle; when the two sets differ, a write to
// the root of the larger set and one to the other root merge them. Edges rejected
// up front (tree complete, node out of range) skip the engine and go to the pending register.
// After reset, and after every 15th clear request, an epoch sweep writes all
// MAX_NODES table entries, one per cycle, while edge_stall stays high.
// A finished result waits in the result register while result_stall is high;
// one further request may be taken and its result held in a pending register,
// and edge_stall then stays high until the result register drains.
module kruskal_union_find_edge_filter #(
  parameter int MAX_NODES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         edge_valid,
  output logic                         edge_stall,
  input  kuf_pkg::in_item_t            edge_item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output kuf_pkg::out_item_t           result_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kuf_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int CLOG_MAX = $clog2(MAX_NODES + 1);
  localparam int CW = (CLOG_MAX > kuf_pkg::COUNT_W) ? CLOG_MAX : kuf_pkg::COUNT_W;
  localparam int COUNT_SPAN = 1 << kuf_pkg::COUNT_W;
  localparam int RESET_COUNT = ((MAX_NODES % COUNT_SPAN) == 0) ? MAX_NODES
                                                               : (MAX_NODES % COUNT_SPAN);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_NODES);

  logic [CW-1:0]                node_count;
  logic [CW-1:0]                active;
  logic [CW-1:0]                remaining;
  logic [kuf_pkg::SUM_W-1:0]    total;
  logic [kuf_pkg::WEIGHT_W-1:0] weight;
  logic                         busy;
  logic                         pend_valid;
  kuf_pkg::out_item_t           pend;

  logic [CW-1:0]             eff_count;
  logic [CW-1:0]             remaining_dec;
  logic [kuf_pkg::SUM_W:0]   sum_wide;
  logic [kuf_pkg::SUM_W-1:0] sum_sat;
  logic                      accept;
  logic                      is_clear;
  logic                      in_range;
  kuf_pkg::eng_cmd_t         cmd;
  kuf_pkg::eng_status_t      status;

  kuf_engine #(
    .MAX_NODES(MAX_NODES)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .status(status)
  );

  assign cfg_ready     = 1'b1;
  assign eff_count     = (node_count == '0) ? CW'(1) :
                         (node_count > MAX_COUNT) ? MAX_COUNT : node_count;
  assign remaining_dec = remaining - CW'(1);
  assign sum_wide      = {1'b0, total} + (kuf_pkg::SUM_W + 1)'(weight);
  assign sum_sat       = sum_wide[kuf_pkg::SUM_W] ? kuf_pkg::SUM_MAX
                                                  : sum_wide[kuf_pkg::SUM_W-1:0];

  assign edge_stall = busy || pend_valid || !status.ready;
  assign accept     = edge_valid && !edge_stall;
  assign is_clear   = (edge_item.req_type == kuf_pkg::REQ_CLEAR);
  assign in_range   = (remaining != '0) && (CW'(edge_item.node_a) < active) &&
                      (CW'(edge_item.node_b) < active);

  assign cmd.start  = accept && (is_clear || in_range);
  assign cmd.clear  = is_clear;
  assign cmd.node_a = edge_item.node_a;
  assign cmd.node_b = edge_item.node_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= CW'(RESET_COUNT);
      active       <= CW'(RESET_COUNT);
      remaining    <= CW'(RESET_COUNT - 1);
      total        <= '0;
      busy         <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= CW'(cfg_data);
      end

      if (accept) begin
        if (is_clear) begin
          active     <= eff_count;
          remaining  <= eff_count - CW'(1);
          total      <= '0;
          pend       <= '{accepted: 1'b0, tree_complete: (eff_count == CW'(1)),
                          total_weight: '0};
          pend_valid <= 1'b1;
        end else if (in_range) begin
          weight <= edge_item.edge_weight;
          busy   <= 1'b1;
        end else begin
          pend       <= '{accepted: 1'b0, tree_complete: (remaining == '0),
                          total_weight: total};
          pend_valid <= 1'b1;
        end
      end

      if (busy && status.done) begin
        busy       <= 1'b0;
        pend_valid <= 1'b1;
        if (status.joined) begin
          remaining <= remaining_dec;
          total     <= sum_sat;
          pend      <= '{accepted: 1'b1, tree_complete: (remaining_dec == '0),
                         total_weight: sum_sat};
        end else begin
          pend <= '{accepted: 1'b0, tree_complete: (remaining == '0),
                    total_weight: total};
        end
      end

      if (pend_valid && (!result_valid || !result_stall)) begin
        result_item  <= pend;
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_done_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |-> busy)
    else $error("engine finished with no edge in flight");

  a_accept_needs_engine: assert property (@(posedge clk) disable iff (rst)
    accept |-> (status.ready && !busy && !pend_valid))
    else $error("transaction accepted while engine or result path occupied");

  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    remaining < active)
    else $error("tree edge count exceeds active node count");

  a_busy_holds_result: assert property (@(posedge clk) disable iff (rst)
    (busy && !status.done) |=> !pend_valid || $past(pend_valid))
    else $error("result produced while edge still in flight");

endmodule

>>> verif/tb_kruskal_union_find_edge_filter.sv
// Testbench for the Kruskal union-find edge filter: queued stimulus, built-in predictor, scoreboard.
`timescale 1ns / 1ps

module tb_kruskal_union_find_edge_filter;

  localparam int MAX_NODES = 4096;
  localparam int QUIET_LIMIT = 5 * (MAX_NODES + 400);
  localparam int ITEM_TARGET = 1200;
  localparam logic [kuf_pkg::WEIGHT_W-1:0] WEIGHT_MAX = {kuf_pkg::WEIGHT_W{1'b1}};

  logic clk;
  logic rst = 1'b1;
  logic edge_valid = 1'b0;
  logic edge_stall;
  kuf_pkg::in_item_t edge_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  kuf_pkg::out_item_t result_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kuf_pkg::COUNT_W-1:0] cfg_data = '0;

  kuf_pkg::in_item_t pending_reqs[$];
  kuf_pkg::out_item_t awaited_verdicts[$];
  int err_count = 0;
  int send_gap = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;

  int uf_link [0:MAX_NODES-1];
  int uf_active;
  int unsigned edges_left;
  logic [kuf_pkg::SUM_W-1:0] uf_sum;
  logic [kuf_pkg::COUNT_W-1:0] uf_node_count = kuf_pkg::COUNT_W'(MAX_NODES);

  kruskal_union_find_edge_filter #(.MAX_NODES(MAX_NODES)) dut (
    .clk          (clk),
    .rst          (rst),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .edge_item    (edge_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_forest();
    for (int i = 0; i < MAX_NODES; i++) uf_link[i] = -1;
    if (uf_node_count == 0) uf_active = 1;
    else if (uf_node_count > MAX_NODES) uf_active = MAX_NODES;
    else uf_active = uf_node_count;
    edges_left = uf_active - 1;
    uf_sum = '0;
  endfunction

  function automatic int find_root(int x);
    int root;
    int nxt;
    int steps;
    root = x;
    steps = 0;
    while (uf_link[root] >= 0 && steps < MAX_NODES) begin
      root = uf_link[root] % MAX_NODES;
      steps++;
    end
    while (x != root && uf_link[x] >= 0) begin
      nxt = uf_link[x] % MAX_NODES;
      uf_link[x] = root;
      x = nxt;
    end
    return root;
  endfunction

  function automatic kuf_pkg::out_item_t mst_filter_step(kuf_pkg::in_item_t req);
    kuf_pkg::out_item_t res;
    int ra;
    int rb;
    int t;
    logic [kuf_pkg::SUM_W:0] s;
    res.accepted = 1'b0;
    if (req.req_type == kuf_pkg::REQ_CLEAR) begin
      reset_forest();
    end else if (edges_left != 0 && req.node_a < uf_active && req.node_b < uf_active) begin
      ra = find_root(req.node_a);
      rb = find_root(req.node_b);
      if (ra != rb) begin
        if (uf_link[ra] > uf_link[rb]) begin
          t = ra;
          ra = rb;
          rb = t;
        end
        uf_link[ra] += uf_link[rb];
        uf_link[rb] = ra;
        edges_left--;
        s = {1'b0, uf_sum} + req.edge_weight;
        uf_sum = (s > kuf_pkg::SUM_MAX) ? kuf_pkg::SUM_MAX : s[kuf_pkg::SUM_W-1:0];
        res.accepted = 1'b1;
      end
    end
    res.tree_complete = (edges_left == 0);
    res.total_weight = uf_sum;
    return res;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [kuf_pkg::WEIGHT_W-1:0] rand_weight();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[kuf_pkg::WEIGHT_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_edge(logic [kuf_pkg::WEIGHT_W-1:0] w, int a, int b);
    kuf_pkg::in_item_t req;
    req.req_type = kuf_pkg::REQ_EDGE;
    req.edge_weight = w;
    req.node_a = kuf_pkg::NODE_W'(a);
    req.node_b = kuf_pkg::NODE_W'(b);
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  task automatic queue_clear();
    kuf_pkg::in_item_t req;
    req.req_type = kuf_pkg::REQ_CLEAR;
    req.edge_weight = rand_weight();
    req.node_a = kuf_pkg::NODE_W'($urandom);
    req.node_b = kuf_pkg::NODE_W'($urandom);
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || edge_valid || awaited_verdicts.size() != 0);
  endtask

  task automatic write_node_count(logic [kuf_pkg::COUNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    uf_node_count = value;
    @(negedge clk);
  endtask

  task automatic check_verdict(kuf_pkg::out_item_t got);
    kuf_pkg::out_item_t want;
    if (awaited_verdicts.size() == 0) begin
      report_mismatch("result transaction with nothing outstanding");
    end else begin
      want = awaited_verdicts.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted %0d, want %0d", got.accepted, want.accepted));
      if (got.tree_complete !== want.tree_complete)
        report_mismatch($sformatf("tree_complete %0d, want %0d",
                                  got.tree_complete, want.tree_complete));
      if (got.total_weight !== want.total_weight)
        report_mismatch($sformatf("total_weight %0d, want %0d",
                                  got.total_weight, want.total_weight));
    end
  endtask

  // driver: advance the request queue, hold payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (edge_valid && !edge_stall)
        awaited_verdicts.insert(awaited_verdicts.size(), mst_filter_step(edge_item));
      if (!edge_valid || !edge_stall) begin
        if (send_gap != 0) begin
          edge_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          edge_item <= pending_reqs.pop_front();
          edge_valid <= 1'b1;
          send_gap <= pick_gap(send_idle);
        end else begin
          edge_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (result_valid && !result_stall) check_verdict(result_item);
      if (hold_cnt != 0) begin
        result_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (recv_idle && $urandom_range(0, 2) == 0) begin
        result_stall <= 1'b1;
        hold_cnt <= pick_gap(1'b1);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (edge_valid && !edge_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int nodes;
    int n_edges;
    int kind;
    int r;
    logic [kuf_pkg::COUNT_W-1:0] count_val;
    logic [kuf_pkg::WEIGHT_W:0] w;
    kuf_pkg::out_item_t left;

    reset_forest();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: defaults after reset, full node range
    queue_edge(0, 0, MAX_NODES - 1);
    queue_clear();
    queue_edge(0, 0, MAX_NODES - 1);
    queue_edge(1, MAX_NODES - 1, 0);
    queue_edge(2, 5, 5);
    queue_edge(3, MAX_NODES - 2, 7);
    queue_edge(WEIGHT_MAX, 1, 2);
    drain();

    write_node_count(kuf_pkg::COUNT_W'(1));
    queue_clear();
    queue_edge(5, 0, 0);
    drain();

    write_node_count(kuf_pkg::COUNT_W'(0));
    queue_clear();
    queue_edge(1, 0, 0);
    drain();

    write_node_count(kuf_pkg::COUNT_W'(3));
    queue_edge(4, 0, 1);
    queue_clear();
    queue_edge(10, 0, 1);
    queue_edge(11, 3, 0);
    queue_edge(12, 0, MAX_NODES - 1);
    queue_edge(13, 1, 2);
    queue_edge(14, 0, 2);
    queue_edge(WEIGHT_MAX, 2, 0);
    drain();

    write_node_count({kuf_pkg::COUNT_W{1'b1}});
    queue_clear();
    queue_edge(WEIGHT_MAX, MAX_NODES - 1, MAX_NODES - 2);
    drain();

    write_node_count(kuf_pkg::COUNT_W'(2));
    queue_clear();
    queue_edge(6, 1, 0);
    drain();

    sent = 0;
    while (sent < ITEM_TARGET) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) count_val = kuf_pkg::COUNT_W'(MAX_NODES);
        else if (r < 11) count_val = kuf_pkg::COUNT_W'($urandom_range(MAX_NODES + 1, 8191));
        else if (r < 15) count_val = kuf_pkg::COUNT_W'($urandom_range(0, 1));
        else if (r < 25) count_val = kuf_pkg::COUNT_W'(2);
        else count_val = kuf_pkg::COUNT_W'($urandom_range(3, 48));
        drain();
        write_node_count(count_val);
      end
      if (uf_node_count == 0) nodes = 1;
      else if (uf_node_count > MAX_NODES) nodes = MAX_NODES;
      else nodes = uf_node_count;
      n_edges = (nodes >= 64) ? $urandom_range(20, 50) : $urandom_range(nodes, 3 * nodes + 4);
      queue_clear();
      sent++;
      w = {1'b0, rand_weight() >> $urandom_range(0, kuf_pkg::WEIGHT_W - 1)};
      for (int i = 0; i < n_edges && sent < ITEM_TARGET; i++) begin
        kind = $urandom_range(0, 99);
        w = w + (rand_weight() >> $urandom_range(24, kuf_pkg::WEIGHT_W - 1));
        if (w > WEIGHT_MAX) w = WEIGHT_MAX;
        if (kind < 85) begin
          queue_edge(w[kuf_pkg::WEIGHT_W-1:0], $urandom_range(0, nodes - 1),
                     $urandom_range(0, nodes - 1));
          sent++;
        end else if (kind < 92) begin
          queue_edge(w[kuf_pkg::WEIGHT_W-1:0], $urandom, $urandom);
          sent++;
        end else if (kind < 96) begin
          queue_clear();
          sent++;
        end else begin
          queue_edge(rand_weight(), $urandom_range(0, nodes - 1), $urandom_range(0, nodes - 1));
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    while (awaited_verdicts.size() != 0) begin
      left = awaited_verdicts.pop_front();
      report_mismatch($sformatf("result never arrived (accepted %0d, total %0d)",
                                left.accepted, left.total_weight));
    end
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
